// ===== sv/largest_empty_square_finder_unit_assert.svh =====
// assertion macros for the largest empty square finder
// used by the top level; clock and reset are named clock and reset
`ifndef LARGEST_EMPTY_SQUARE_FINDER_UNIT_ASSERT_SVH
`define LARGEST_EMPTY_SQUARE_FINDER_UNIT_ASSERT_SVH

// same-cycle implication
`define LESF_ASSERT_NOW(label, cond, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |-> (prop)) \
      else $error(msg);

// next-cycle implication
`define LESF_ASSERT_NEXT(label, cond, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |=> (prop)) \
      else $error(msg);

`endif

// ===== sv/lesf_pkg.sv =====
// shared types and constants for the largest empty square finder
// no dependencies
package lesf_pkg;

   // configuration port
   localparam int CSR_DATA_W = 11;
   localparam int CSR_IDX_W  = 2;
   localparam logic [CSR_IDX_W-1:0] CSR_GRID_COLS = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_GRID_ROWS = 2'd1;
   localparam logic [CSR_DATA_W-1:0] GRID_SIZE_RESET = 11'd1024;

   // default largest supported grid side
   localparam int DEFAULT_MAX_SIDE = 1024;

   // position flags of one cell within the frame
   typedef struct packed {
      logic col_first;
      logic row_first;
      logic row_end;
      logic frame_end;
   } cell_flags_type;

endpackage

// ===== sv/lesf_if.sv =====
// valid/ready channel interfaces for cell words and result words
// no dependencies
interface lesf_req_if;
   logic valid;
   logic ready;
   logic is_obstacle;

   modport source (output valid, output is_obstacle, input ready);
   modport sink (input valid, input is_obstacle, output ready);
endinterface

interface lesf_rsp_if #(
   parameter int SIDE_W = 11,
   parameter int POS_W  = 10
);
   logic              valid;
   logic              ready;
   logic [SIDE_W-1:0] square_side;
   logic [POS_W-1:0]  square_col;
   logic [POS_W-1:0]  square_row;

   modport source (output valid, output square_side, output square_col,
                   output square_row, input ready);
   modport sink (input valid, input square_side, input square_col,
                 input square_row, output ready);
endinterface

// ===== sv/lesf_scan_ctrl.sv =====
// frame size registers and row/column scan counters
// depends on lesf_pkg
module lesf_scan_ctrl
   import lesf_pkg::*;
#(
   parameter int MAX_SIDE = DEFAULT_MAX_SIDE,
   localparam int POS_W = $clog2(MAX_SIDE)
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_idx,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   input  logic                  step,
   output logic [POS_W-1:0]      col,
   output logic [POS_W-1:0]      row,
   output cell_flags_type        flags
);

   logic [CSR_DATA_W-1:0] grid_cols_ff;
   logic [CSR_DATA_W-1:0] grid_rows_ff;
   logic [POS_W-1:0]      col_count_ff, col_count_in;
   logic [POS_W-1:0]      row_count_ff, row_count_in;
   logic [POS_W-1:0]      last_col;
   logic [POS_W-1:0]      last_row;

   // size registers
   always_ff @(posedge clock) begin
      if (reset) begin
         grid_cols_ff <= GRID_SIZE_RESET;
         grid_rows_ff <= GRID_SIZE_RESET;
      end else if (csr_we) begin
         case (csr_idx)
            CSR_GRID_COLS: grid_cols_ff <= csr_wdata;
            CSR_GRID_ROWS: grid_rows_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // last index in use: zero acts as one, oversize clamps to the max side
   always_comb begin
      if (grid_cols_ff == '0)
         last_col = '0;
      else if (32'(grid_cols_ff) > 32'(MAX_SIDE))
         last_col = POS_W'(MAX_SIDE - 1);
      else
         last_col = POS_W'(grid_cols_ff - 1'b1);

      if (grid_rows_ff == '0)
         last_row = '0;
      else if (32'(grid_rows_ff) > 32'(MAX_SIDE))
         last_row = POS_W'(MAX_SIDE - 1);
      else
         last_row = POS_W'(grid_rows_ff - 1'b1);
   end

   // flags of the cell at the current position
   always_comb begin
      flags.col_first = (col_count_ff == '0);
      flags.row_first = (row_count_ff == '0);
      flags.row_end   = (col_count_ff >= last_col);
      flags.frame_end = flags.row_end && (row_count_ff >= last_row);
   end

   // next position
   always_comb begin
      col_count_in = col_count_ff;
      row_count_in = row_count_ff;
      if (step) begin
         if (flags.row_end) begin
            col_count_in = '0;
            row_count_in = flags.frame_end ? '0 : row_count_ff + 1'b1;
         end else begin
            col_count_in = col_count_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_count_ff <= '0;
         row_count_ff <= '0;
      end else begin
         col_count_ff <= col_count_in;
         row_count_ff <= row_count_in;
      end
   end

   assign col = col_count_ff;
   assign row = row_count_ff;

endmodule

// ===== sv/lesf_line_store.sv =====
// one-row line store of square sides with registered read and write bypass
// depends on lesf_pkg
module lesf_line_store
   import lesf_pkg::*;
#(
   parameter int MAX_SIDE = DEFAULT_MAX_SIDE,
   localparam int SIDE_W = $clog2(MAX_SIDE + 1),
   localparam int POS_W  = $clog2(MAX_SIDE)
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              rd_en,
   input  logic [POS_W-1:0]  rd_addr,
   input  logic              wr_en,
   input  logic [POS_W-1:0]  wr_addr,
   input  logic [SIDE_W-1:0] wr_data,
   output logic [SIDE_W-1:0] rd_data
);

   logic [SIDE_W-1:0] mem [MAX_SIDE];
   logic [SIDE_W-1:0] rd_data_ff;
   logic [SIDE_W-1:0] byp_data_ff;
   logic              byp_ff;

   // memory array
   always_ff @(posedge clock) begin
      if (wr_en)
         mem[wr_addr] <= wr_data;
      if (rd_en)
         rd_data_ff <= mem[rd_addr];
   end

   // a read of the entry being written takes the new value
   always_ff @(posedge clock) begin
      if (reset) begin
         byp_ff <= 1'b0;
      end else if (rd_en) begin
         byp_ff <= wr_en && (wr_addr == rd_addr);
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en)
         byp_data_ff <= wr_data;
   end

   assign rd_data = byp_ff ? byp_data_ff : rd_data_ff;

endmodule

// ===== sv/lesf_best_track.sv =====
// running best square and result register
// depends on lesf_pkg and lesf_rsp_if
module lesf_best_track
   import lesf_pkg::*;
#(
   parameter int MAX_SIDE = DEFAULT_MAX_SIDE,
   localparam int SIDE_W = $clog2(MAX_SIDE + 1),
   localparam int POS_W  = $clog2(MAX_SIDE)
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              step,
   input  logic              frame_end,
   input  logic [SIDE_W-1:0] side,
   input  logic [POS_W-1:0]  col,
   input  logic [POS_W-1:0]  row,
   output logic              out_free,
   lesf_rsp_if.source        rsp
);

   logic [SIDE_W-1:0] best_side_ff, best_side_in;
   logic [POS_W-1:0]  best_col_ff, best_col_in;
   logic [POS_W-1:0]  best_row_ff, best_row_in;
   logic              rsp_valid_ff;
   logic [SIDE_W-1:0] rsp_side_ff;
   logic [POS_W-1:0]  rsp_col_ff;
   logic [POS_W-1:0]  rsp_row_ff;

   // strictly larger side replaces the best; top-left is end plus one minus side
   always_comb begin
      best_side_in = best_side_ff;
      best_col_in  = best_col_ff;
      best_row_in  = best_row_ff;
      if (side > best_side_ff) begin
         best_side_in = side;
         best_col_in  = POS_W'(SIDE_W'(col) + 1'b1 - side);
         best_row_in  = POS_W'(SIDE_W'(row) + 1'b1 - side);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         best_side_ff <= '0;
         best_col_ff  <= '0;
         best_row_ff  <= '0;
      end else if (step) begin
         if (frame_end) begin
            best_side_ff <= '0;
            best_col_ff  <= '0;
            best_row_ff  <= '0;
         end else begin
            best_side_ff <= best_side_in;
            best_col_ff  <= best_col_in;
            best_row_ff  <= best_row_in;
         end
      end
   end

   // result word register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (step && frame_end) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (step && frame_end) begin
         rsp_side_ff <= best_side_in;
         rsp_col_ff  <= best_col_in;
         rsp_row_ff  <= best_row_in;
      end
   end

   assign out_free        = !rsp_valid_ff || rsp.ready;
   assign rsp.valid       = rsp_valid_ff;
   assign rsp.square_side = rsp_side_ff;
   assign rsp.square_col  = rsp_col_ff;
   assign rsp.square_row  = rsp_row_ff;

endmodule

// ===== sv/largest_empty_square_finder_unit.sv =====
// Largest empty square finder: takes one obstacle bit per cell in row-major
// order and, after the last cell of each frame, returns the side and top-left
// position of the first largest obstacle-free square. One cell word is taken
// every clock. A cell is held in the cell register, where the
// line-store read, the three-way minimum and the best compare are done, and
// its result word (on the last cell of a frame) is shown the cycle after it
// leaves. The single read and single write port of the line store are used
// once per cell, so the rate is one cell per clock; the input stalls only
// when a frame ends while the previous result word is still not taken.
// No clearing pass after reset is needed.
// depends on lesf_pkg, lesf_if, lesf_scan_ctrl, lesf_line_store, lesf_best_track
`include "largest_empty_square_finder_unit_assert.svh"

module largest_empty_square_finder_unit
   import lesf_pkg::*;
#(
   parameter int MAX_SIDE = DEFAULT_MAX_SIDE,
   localparam int SIDE_W = $clog2(MAX_SIDE + 1),
   localparam int POS_W  = $clog2(MAX_SIDE)
) (
   input  logic                  clock,
   input  logic                  reset,
   lesf_req_if.sink              req_chan,
   lesf_rsp_if.source            rsp_chan,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_idx,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   logic              accept;
   logic              s1_adv;
   logic              out_free;
   logic [POS_W-1:0]  scan_col;
   logic [POS_W-1:0]  scan_row;
   cell_flags_type    scan_flags;

   logic              s1_valid_ff;
   logic              s1_obst_ff;
   logic [POS_W-1:0]  s1_col_ff;
   logic [POS_W-1:0]  s1_row_ff;
   cell_flags_type    s1_flags_ff;
   logic [SIDE_W-1:0] left_ff;
   logic [SIDE_W-1:0] diag_ff;

   logic [SIDE_W-1:0] line_up;
   logic [SIDE_W-1:0] up;
   logic [SIDE_W-1:0] min_lu;
   logic [SIDE_W-1:0] min3;
   logic [SIDE_W:0]   side_raw;
   logic [POS_W-1:0]  min_pos;
   logic [SIDE_W:0]   bound;
   logic [SIDE_W-1:0] side;

   // handshake
   assign s1_adv         = s1_valid_ff && (!s1_flags_ff.frame_end || out_free);
   assign req_chan.ready = !s1_valid_ff || s1_adv;
   assign accept         = req_chan.valid && req_chan.ready;

   // scan position and frame size
   lesf_scan_ctrl #(.MAX_SIDE(MAX_SIDE)) u_scan (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_idx   (csr_idx),
      .csr_wdata (csr_wdata),
      .step      (accept),
      .col       (scan_col),
      .row       (scan_row),
      .flags     (scan_flags)
   );

   // line store: read at accept, write when the cell leaves the register
   lesf_line_store #(.MAX_SIDE(MAX_SIDE)) u_line (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (accept),
      .rd_addr (scan_col),
      .wr_en   (s1_adv),
      .wr_addr (s1_col_ff),
      .wr_data (side),
      .rd_data (line_up)
   );

   // cell register
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (accept) begin
         s1_valid_ff <= 1'b1;
      end else if (s1_adv) begin
         s1_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_obst_ff  <= req_chan.is_obstacle;
         s1_col_ff   <= scan_col;
         s1_row_ff   <= scan_row;
         s1_flags_ff <= scan_flags;
      end
   end

   // side of the square ending at this cell
   always_comb begin
      up       = s1_flags_ff.row_first ? '0 : line_up;
      min_lu   = (up < left_ff) ? up : left_ff;
      min3     = (min_lu < diag_ff) ? min_lu : diag_ff;
      if (s1_obst_ff)
         side_raw = '0;
      else if (s1_flags_ff.col_first || s1_flags_ff.row_first)
         side_raw = (SIDE_W + 1)'(1);
      else
         side_raw = (SIDE_W + 1)'(min3) + 1'b1;
      min_pos  = (s1_col_ff < s1_row_ff) ? s1_col_ff : s1_row_ff;
      bound    = (SIDE_W + 1)'(min_pos) + 1'b1;
      side     = (side_raw > bound) ? SIDE_W'(bound) : SIDE_W'(side_raw);
   end

   // left and diagonal neighbors, cleared at the end of each row
   always_ff @(posedge clock) begin
      if (reset) begin
         left_ff <= '0;
         diag_ff <= '0;
      end else if (s1_adv) begin
         if (s1_flags_ff.row_end) begin
            left_ff <= '0;
            diag_ff <= '0;
         end else begin
            left_ff <= side;
            diag_ff <= up;
         end
      end
   end

   // best square and result word
   lesf_best_track #(.MAX_SIDE(MAX_SIDE)) u_best (
      .clock     (clock),
      .reset     (reset),
      .step      (s1_adv),
      .frame_end (s1_flags_ff.frame_end),
      .side      (side),
      .col       (s1_col_ff),
      .row       (s1_row_ff),
      .out_free  (out_free),
      .rsp       (rsp_chan)
   );

   // checks
   `LESF_ASSERT_NOW(a_rsp_after_frame_end, $rose(rsp_chan.valid), $past(s1_adv && s1_flags_ff.frame_end), "result word without a frame end")
   `LESF_ASSERT_NOW(a_stall_only_on_result, s1_valid_ff && !s1_adv, s1_flags_ff.frame_end && rsp_chan.valid && !rsp_chan.ready, "cell held without a pending result")
   `LESF_ASSERT_NEXT(a_frame_wraps, accept && scan_flags.frame_end, scan_col == '0 && scan_row == '0, "scan position not cleared after frame end")
   `LESF_ASSERT_NEXT(a_row_clears_neighbors, s1_adv && s1_flags_ff.row_end, left_ff == '0 && diag_ff == '0, "neighbors not cleared at row end")

endmodule

// ===== tb/lesf_square_check.sv =====
// result checker for the largest empty square finder: mirrors the scan state,
// queues the expected square word per frame and compares each result word
// depends on lesf_pkg and lesf_if
`timescale 1ns / 1ps

module lesf_square_check
   import lesf_pkg::*;
#(
   parameter int MAX_SIDE = DEFAULT_MAX_SIDE
) (
   input  logic                  clock,
   input  logic                  reset,
   lesf_req_if                   req_mon,
   lesf_rsp_if                   rsp_mon,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_idx,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output int                    fail_count,
   output int                    pending_count
);

   typedef struct packed {
      logic [10:0] side;
      logic [9:0]  col;
      logic [9:0]  row;
   } square_word_type;

   // mirrored registers and scan state
   logic [CSR_DATA_W-1:0] cols_reg;
   logic [CSR_DATA_W-1:0] rows_reg;
   logic [10:0]           line_sides [MAX_SIDE];
   int unsigned           left_run;
   int unsigned           diag_run;
   int unsigned           col_pos;
   int unsigned           row_pos;
   int unsigned           top_side;
   int unsigned           top_col;
   int unsigned           top_row;

   square_word_type expected_squares [$];

   // zero acts as one, oversized values clamp to the largest side
   function automatic int unsigned grid_extent(input logic [CSR_DATA_W-1:0] raw);
      if (raw == '0) return 1;
      if (raw > MAX_SIDE) return MAX_SIDE;
      return 32'(raw);
   endfunction

   // one cell through the square recurrence; queues a word on frame end
   task automatic scan_cell(input logic obstacle);
      int unsigned     ncols;
      int unsigned     nrows;
      int unsigned     c;
      int unsigned     r;
      int unsigned     up;
      int unsigned     side;
      int unsigned     bound;
      bit              row_end;
      bit              frame_end;
      square_word_type sq;
      ncols = grid_extent(cols_reg);
      nrows = grid_extent(rows_reg);
      c = (col_pos >= MAX_SIDE) ? MAX_SIDE - 1 : col_pos;
      r = (row_pos >= MAX_SIDE) ? MAX_SIDE - 1 : row_pos;
      up = (r != 0) ? int'(line_sides[c]) : 0;

      if (obstacle) begin
         side = 0;
      end else if (c == 0 || r == 0) begin
         side = 1;
      end else begin
         side = (up < left_run) ? up : left_run;
         side = 1 + ((side < diag_run) ? side : diag_run);
      end
      // keeps the top-left corner inside the grid after stale line reads
      bound = ((c < r) ? c : r) + 1;
      if (side > bound) side = bound;

      line_sides[c] = side[10:0];
      diag_run = up;
      left_run = side;

      // strictly larger only, so the first square in scan order stays
      if (side > top_side) begin
         top_side = side;
         top_col  = c + 1 - side;
         top_row  = r + 1 - side;
      end

      row_end   = (c + 1 >= ncols);
      frame_end = row_end && (r + 1 >= nrows);
      if (row_end) begin
         col_pos  = 0;
         left_run = 0;
         diag_run = 0;
         row_pos  = frame_end ? 0 : r + 1;
      end else begin
         col_pos = c + 1;
         row_pos = r;
      end

      if (frame_end) begin
         sq.side = top_side[10:0];
         sq.col  = top_col[9:0];
         sq.row  = top_row[9:0];
         expected_squares.push_back(sq);
         top_side = 0;
         top_col  = 0;
         top_row  = 0;
      end
   endtask

   always @(posedge clock) begin
      square_word_type exp_sq;
      if (reset) begin
         cols_reg   = GRID_SIZE_RESET;
         rows_reg   = GRID_SIZE_RESET;
         left_run   = 0;
         diag_run   = 0;
         col_pos    = 0;
         row_pos    = 0;
         top_side   = 0;
         top_col    = 0;
         top_row    = 0;
         fail_count = 0;
         for (int i = 0; i < MAX_SIDE; i++) line_sides[i] = '0;
         expected_squares.delete();
      end else begin
         // result word against the oldest expectation
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (expected_squares.size() == 0) begin
               $error("result word with nothing expected: side %0d col %0d row %0d",
                      rsp_mon.square_side, rsp_mon.square_col, rsp_mon.square_row);
               fail_count++;
            end else begin
               exp_sq = expected_squares.pop_front();
               if (rsp_mon.square_side !== exp_sq.side) begin
                  $error("square_side: expected %0d, got %0d", exp_sq.side,
                         rsp_mon.square_side);
                  fail_count++;
               end
               if (rsp_mon.square_col !== exp_sq.col) begin
                  $error("square_col: expected %0d, got %0d", exp_sq.col,
                         rsp_mon.square_col);
                  fail_count++;
               end
               if (rsp_mon.square_row !== exp_sq.row) begin
                  $error("square_row: expected %0d, got %0d", exp_sq.row,
                         rsp_mon.square_row);
                  fail_count++;
               end
            end
         end

         // accepted cell word
         if (req_mon.valid && req_mon.ready) scan_cell(req_mon.is_obstacle);

         // register writes apply from the next cell on
         if (csr_we) begin
            case (csr_idx)
               CSR_GRID_COLS: cols_reg = csr_wdata;
               CSR_GRID_ROWS: rows_reg = csr_wdata;
               default: ;
            endcase
         end
      end
      pending_count = expected_squares.size();
   end

endmodule

// ===== tb/largest_empty_square_finder_unit_tb.sv =====
// top of the largest empty square finder testbench: clock, reset, cell and
// register stimulus, receiver stalls and the verdict
// depends on lesf_pkg, lesf_if, lesf_square_check and the block itself
`timescale 1ns / 1ps

module largest_empty_square_finder_unit_tb;
   import lesf_pkg::*;

   localparam int CYCLE_LIMIT  = 500000;
   localparam int DRAIN_CYCLES = 4;
   localparam int RANDOM_CELLS = 180;
   localparam int LONG_HOLD    = 300;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_idx;
   logic [CSR_DATA_W-1:0] csr_wdata;

   int send_idle_pct = 16;
   int recv_idle_pct = 47;
   int hold_left     = 0;
   bit hold_arm      = 1'b0;
   bit hold_taken    = 1'b0;
   int cycle_count   = 0;
   int random_cells  = 0;
   int fail_count;
   int pending_count;

   lesf_req_if req_chan ();
   lesf_rsp_if rsp_chan ();

   largest_empty_square_finder_unit u_top (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan),
      .csr_we    (csr_we),
      .csr_idx   (csr_idx),
      .csr_wdata (csr_wdata)
   );

   lesf_square_check u_check (
      .clock         (clock),
      .reset         (reset),
      .req_mon       (req_chan),
      .rsp_mon       (rsp_chan),
      .csr_we        (csr_we),
      .csr_idx       (csr_idx),
      .csr_wdata     (csr_wdata),
      .fail_count    (fail_count),
      .pending_count (pending_count)
   );

   always #1 clock = ~clock;

   // receiver: random stalls, or one long hold-off once armed
   always @(posedge clock) begin
      if (hold_arm && !hold_taken) begin
         hold_left  = LONG_HOLD;
         hold_taken = 1'b1;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_chan.ready <= 1'b0;
      end else begin
         rsp_chan.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   // one cell word, with random gaps ahead of it
   task automatic send_cell(input bit obstacle);
      while ($urandom_range(99) < send_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid       <= 1'b1;
      req_chan.is_obstacle <= obstacle;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
   endtask

   // stop sending and wait until every expected word is back
   task automatic drain();
      req_chan.valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input int unsigned value);
      csr_we    <= 1'b1;
      csr_idx   <= idx;
      csr_wdata <= value[CSR_DATA_W-1:0];
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   // frame size change, only once the block is idle
   task automatic set_grid(input int unsigned ncols, input int unsigned nrows);
      drain();
      csr_we    <= 1'b1;
      csr_idx   <= CSR_GRID_COLS;
      csr_wdata <= ncols[CSR_DATA_W-1:0];
      @(posedge clock);
      csr_idx   <= CSR_GRID_ROWS;
      csr_wdata <= nrows[CSR_DATA_W-1:0];
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   // one to three frames of one size; sometimes cut off mid-frame
   task automatic random_frames();
      int unsigned ncols;
      int unsigned nrows;
      int unsigned frame_cells;
      int unsigned cells;
      int unsigned density;
      ncols = ($urandom_range(9) == 0) ? $urandom_range(9, 16) : $urandom_range(1, 8);
      nrows = ($urandom_range(9) == 0) ? $urandom_range(9, 16) : $urandom_range(1, 8);
      if (ncols * nrows > 64) nrows = 64 / ncols;
      frame_cells = ncols * nrows;
      // a size of one is sometimes written as zero
      set_grid((ncols == 1 && $urandom_range(1) == 1) ? 0 : ncols,
               (nrows == 1 && $urandom_range(1) == 1) ? 0 : nrows);
      cells = frame_cells * $urandom_range(1, 2);
      if ($urandom_range(7) == 0) cells += $urandom_range(1, frame_cells);
      case ($urandom_range(7))
         0:       density = 100;
         1, 2:    density = 0;
         default: density = $urandom_range(0, 50);
      endcase
      for (int unsigned i = 0; i < cells; i++) send_cell($urandom_range(99) < density);
      random_cells += cells;
   endtask

   initial begin
      req_chan.valid       = 1'b0;
      req_chan.is_obstacle = 1'b0;
      csr_we               = 1'b0;
      csr_idx              = CSR_GRID_COLS;
      csr_wdata            = '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // single-cell frames, also with zero sizes acting as one
      set_grid(1, 1);
      send_cell(1'b0);
      send_cell(1'b1);
      set_grid(0, 0);
      send_cell(1'b1);
      send_cell(1'b0);

      // all obstacles, then all empty
      set_grid(3, 3);
      repeat (9) send_cell(1'b1);
      repeat (9) send_cell(1'b0);

      // equal squares: the first one found is kept
      set_grid(4, 2);
      repeat (8) send_cell(1'b0);

      // width grows mid-frame over stale line entries
      set_grid(8, 4);
      repeat (32) send_cell(1'b0);
      set_grid(4, 6);
      repeat (10) send_cell(1'b0);
      drain();
      write_reg(CSR_GRID_COLS, 8);
      repeat (30) send_cell(1'b0);

      // width shrinks mid-row, ending the row at once
      set_grid(8, 3);
      repeat (5) send_cell(1'b0);
      drain();
      write_reg(CSR_GRID_COLS, 3);
      repeat (7) send_cell(1'b0);

      // height shrinks below the current row, ending the frame on that row
      set_grid(3, 5);
      repeat (9) send_cell(1'b0);
      drain();
      write_reg(CSR_GRID_ROWS, 2);
      repeat (3) send_cell(1'b0);

      // widest row: oversized width acts as the largest side, last column empty
      set_grid(2047, 1);
      for (int i = 0; i < 1024; i++) send_cell(i != 1023);

      // receiver holds off while small frames keep ending
      set_grid(2, 2);
      hold_arm = 1'b1;
      repeat (40) send_cell($urandom_range(3) == 0);

      // random frames in three idling phases
      while (random_cells < RANDOM_CELLS) begin
         if (random_cells < RANDOM_CELLS / 3) begin
            send_idle_pct = 16;
            recv_idle_pct = 47;
         end else if (random_cells < 2 * RANDOM_CELLS / 3) begin
            send_idle_pct = 47;
            recv_idle_pct = 16;
         end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         random_frames();
      end

      drain();
      if (fail_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
